// File: rtl/dha_pkg.sv
`timescale 1ns / 1ps

package dha_pkg;

    localparam int KIND_W     = 3;
    localparam int INDEX_W    = 4;
    localparam int CODE_W     = 2;
    localparam int NOW_W      = 48;
    localparam int ATT_W      = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [KIND_W-1:0] {
        K_ADD       = 3'd0,
        K_SUPPORTED = 3'd1,
        K_MAINT     = 3'd2,
        K_REACH     = 3'd3,
        K_STREAM    = 3'd4,
        K_STORAGE   = 3'd5,
        K_ACK       = 3'd6,
        K_QUERY     = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_UNKNOWN     = 3'd0,
        ST_ONLINE      = 3'd1,
        ST_DEGRADED    = 3'd2,
        ST_OFFLINE     = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        RSN_NONE        = 3'd0,
        RSN_UNSUPPORTED = 3'd1,
        RSN_OFFLINE     = 3'd2,
        RSN_STREAM_FAIL = 3'd3,
        RSN_STORAGE_FAIL = 3'd4,
        RSN_STREAM_DEG  = 3'd5,
        RSN_STORAGE_LOW = 3'd6
    } t_reason;

    // status codes of reach, stream and storage reports
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 2'd0;
    localparam logic [CODE_W-1:0] CODE_OK      = 2'd1;
    localparam logic [CODE_W-1:0] CODE_LOW     = 2'd2;
    localparam logic [CODE_W-1:0] CODE_FAILED  = 2'd3;

    typedef struct packed {
        logic [1:0]         pad;
        logic [NOW_W-1:0]   now_ms;
        logic [CODE_W-1:0]  value;
        logic [INDEX_W-1:0] device_index;
    } t_in_data;

    typedef struct packed {
        logic [4:0]       pad;
        logic [ATT_W-1:0] attention_map;
        logic             notify_now;
        logic [NOW_W-1:0] alarm_since_ms;
        t_reason          reason_code;
        logic             maintenance_mode;
        logic             alarm_acked;
        logic             alarm_active;
        t_state           overall_state;
        logic             entry_exists;
    } t_out_data;

    typedef struct packed {
        logic              supported;
        logic [CODE_W-1:0] reach;
        logic [CODE_W-1:0] stream;
        logic [CODE_W-1:0] storage;
        t_state            state;
        logic              active;
        logic              acked;
        logic              maint;
        t_reason           reason;
    } t_entry;

    localparam t_entry ENTRY_INIT = '{
        supported: 1'b1,
        reach:     CODE_UNKNOWN,
        stream:    CODE_UNKNOWN,
        storage:   CODE_UNKNOWN,
        state:     ST_UNKNOWN,
        active:    1'b0,
        acked:     1'b0,
        maint:     1'b0,
        reason:    RSN_NONE
    };

    function automatic t_state derive_state(t_entry e);
        t_state st;
        if (!e.supported) begin
            st = ST_UNSUPPORTED;
        end else if (e.reach == CODE_LOW) begin
            st = ST_OFFLINE;
        end else if (e.reach == CODE_UNKNOWN) begin
            st = ST_UNKNOWN;
        end else if (e.stream[1] || e.storage[1]) begin
            st = ST_DEGRADED;
        end else begin
            st = ST_ONLINE;
        end
        return st;
    endfunction

    function automatic t_reason worst_reason(t_entry e);
        t_reason r;
        if (!e.supported) begin
            r = RSN_UNSUPPORTED;
        end else if (e.reach == CODE_LOW) begin
            r = RSN_OFFLINE;
        end else if (e.stream == CODE_FAILED) begin
            r = RSN_STREAM_FAIL;
        end else if (e.storage == CODE_FAILED) begin
            r = RSN_STORAGE_FAIL;
        end else if (e.stream == CODE_LOW) begin
            r = RSN_STREAM_DEG;
        end else if (e.storage == CODE_LOW) begin
            r = RSN_STORAGE_LOW;
        end else begin
            r = RSN_NONE;
        end
        return r;
    endfunction

endpackage

// File: rtl/device_health_alarm_table.sv
`timescale 1ns / 1ps

// Device health alarm table.
// Input channel s_axis: one event per transfer, kind in tuser, device index,
// value and timestamp in tdata. Output channel m_axis: one result per event,
// the addressed entry after the event, its notify flag and the attention map
// of all devices.
// An event is first held in the input register; the entry update and the
// result are then registered together in the output register.
// Throughput is one event per cycle while the receiver does not stall; the
// table is in flip-flops, so an event sees the update of the event right
// before it with no bubble.
// Reset clears every entry's valid bit and the valid flags of both pipeline
// stages; entries are initialized by an add event.
// When the receiver stalls, the result is held in the output register and the
// input register fills; s_axis_tready then drops until m_axis_tready returns.
// Events other than add for devices not yet added change nothing and return zero entry fields.
module device_health_alarm_table #(
    parameter int NUM_DEVICES = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // device_index[3:0], value[5:4], now_ms[53:6], zero pad
    input  logic [dha_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [dha_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // entry_exists[0], overall_state[3:1], alarm_active[4], alarm_acked[5],
    // maintenance_mode[6], reason_code[9:7], alarm_since_ms[57:10],
    // notify_now[58], attention_map[74:59], zero pad
    output logic [dha_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import dha_pkg::*;

    localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    logic                 r_in_valid;
    t_kind                r_kind;
    t_in_data             r_in;
    logic                 r_out_valid;
    t_out_data            r_out;

    logic [NUM_DEVICES-1:0] r_valid;
    t_entry                 r_ent   [NUM_DEVICES];
    logic [TIME_BITS-1:0]   r_since [NUM_DEVICES];

    logic                 w_advance;
    logic                 w_in_range;
    logic [IDX_W-1:0]     w_ix;
    logic                 w_cur_valid;
    t_entry               w_cur;
    logic [TIME_BITS-1:0] w_cur_since;
    logic [63:0]          w_now_ext;
    logic [TIME_BITS-1:0] w_now_t;
    logic                 w_refresh;
    t_state               w_st;
    logic                 w_we;
    logic                 n_valid;
    t_entry               n_ent;
    logic [TIME_BITS-1:0] n_since;
    logic [63:0]          w_since_ext;
    logic                 w_exists;
    logic [ATT_W-1:0]     w_att;
    t_out_data            n_out;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        w_in_range  = (int'(r_in.device_index) < NUM_DEVICES);
        w_ix        = IDX_W'(r_in.device_index);
        w_cur_valid = w_in_range && r_valid[w_ix];
        w_cur       = r_ent[w_ix];
        w_cur_since = r_since[w_ix];
        w_now_ext   = 64'(r_in.now_ms);
        w_now_t     = w_now_ext[TIME_BITS-1:0];

        n_valid   = w_cur_valid;
        n_ent     = w_cur;
        n_since   = w_cur_since;
        w_refresh = 1'b0;

        unique case (r_kind)
            K_ADD: begin
                if (!w_cur_valid) begin
                    n_valid = 1'b1;
                    n_ent   = ENTRY_INIT;
                    n_since = '0;
                end
            end
            K_SUPPORTED: begin
                n_ent.supported = |r_in.value;
                w_refresh       = 1'b1;
            end
            K_MAINT: n_ent.maint = |r_in.value;
            K_REACH: begin
                // failed reach folds into offline
                n_ent.reach = r_in.value[1] ? CODE_LOW : r_in.value;
                w_refresh   = 1'b1;
            end
            K_STREAM: begin
                n_ent.stream = r_in.value;
                w_refresh    = 1'b1;
            end
            K_STORAGE: begin
                n_ent.storage = r_in.value;
                w_refresh     = 1'b1;
            end
            K_ACK: begin
                if (w_cur.active) n_ent.acked = 1'b1;
            end
            K_QUERY: ;
        endcase

        w_st = derive_state(n_ent);
        if (w_refresh) begin
            n_ent.state = w_st;
            if (w_st == ST_OFFLINE || w_st == ST_DEGRADED || w_st == ST_UNSUPPORTED) begin
                if (!n_ent.active) begin
                    n_ent.active = 1'b1;
                    n_ent.acked  = 1'b0;
                    n_since      = w_now_t;
                end
                n_ent.reason = worst_reason(n_ent);
            end else if (n_ent.active) begin
                n_ent.active = 1'b0;
                n_ent.acked  = 1'b0;
                n_ent.reason = RSN_NONE;
                n_since      = '0;
            end
        end

        w_we = w_advance && w_in_range && ((r_kind == K_ADD) ? !w_cur_valid : w_cur_valid);
    end

    // attention bits see this event's update of its own entry
    for (genvar g = 0; g < ATT_W; g++) begin : g_att
        if (g < NUM_DEVICES) begin : g_dev
            logic w_hit;
            assign w_hit    = w_in_range && (w_ix == IDX_W'(g));
            assign w_att[g] = w_hit
                ? (n_valid && n_ent.active && !n_ent.acked && !n_ent.maint)
                : (r_valid[g] && r_ent[g].active && !r_ent[g].acked && !r_ent[g].maint);
        end else begin : g_none
            assign w_att[g] = 1'b0;
        end
    end

    always_comb begin
        w_since_ext = 64'(n_since);
        w_exists    = w_in_range && n_valid;
        n_out       = '0;
        if (w_exists) begin
            n_out.entry_exists     = 1'b1;
            n_out.overall_state    = n_ent.state;
            n_out.alarm_active     = n_ent.active;
            n_out.alarm_acked      = n_ent.acked;
            n_out.maintenance_mode = n_ent.maint;
            n_out.reason_code      = n_ent.reason;
            n_out.alarm_since_ms   = w_since_ext[NOW_W-1:0];
            n_out.notify_now       = n_ent.active && !n_ent.acked && !n_ent.maint;
        end
        n_out.attention_map = w_att;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_valid[w_ix] <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_in   <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
        if (w_we) begin
            r_ent[w_ix]   <= n_ent;
            r_since[w_ix] <= n_since;
        end
    end

endmodule
